>>> rtl/bcm_pkg.sv
// shared types, codes and constants of the led scan block
// no dependencies; imported by every module of the block
package bcm_pkg;

  localparam int SEGMENTS_DEF         = 8;
  localparam int MAX_PLANES_DEF       = 10;
  localparam int DRIVER_WORD_BITS_DEF = 32;
  localparam int QUEUE_DEPTH          = 4;
  localparam int QCNT_W               = $clog2(QUEUE_DEPTH + 1);

  // request actions
  localparam logic [1:0] ACT_WRITE_WORD   = 2'd0;
  localparam logic [1:0] ACT_WRITE_BRIGHT = 2'd1;
  localparam logic [1:0] ACT_SWAP         = 2'd2;
  localparam logic [1:0] ACT_BIT_CYCLE    = 2'd3;

  // register indexes
  localparam logic [1:0] CFG_BIT_PLANES    = 2'd0;
  localparam logic [1:0] CFG_PERIOD_BASE   = 2'd1;
  localparam logic [1:0] CFG_PERIOD_OFFSET = 2'd2;

  localparam logic [3:0] BIT_PLANES_RST    = 4'd10;
  localparam logic [6:0] PERIOD_BASE_RST   = 7'd4;
  localparam logic [7:0] PERIOD_OFFSET_RST = 8'd9;

  localparam logic KIND_DRIVER = 1'b0;
  localparam logic KIND_AUX    = 1'b1;

  localparam logic [15:0] AUX_SEL_ALL   = 16'hff00;
  localparam logic [15:0] AUX_SEL_ONE   = 16'h0100;
  localparam logic [15:0] AUX_BRIGHT_HI = 16'h0080;
  localparam logic [15:0] AUX_BRIGHT_LO = 16'h0040;
  localparam logic [15:0] PERIOD_MAX    = 16'hffff;

  typedef struct packed {
    logic        wrap;
    logic [31:0] word;
    logic [15:0] period;
    logic [2:0]  read_seg;
    logic [3:0]  plane;
    logic [15:0] aux;
    logic [2:0]  aux_seg;
  } job_t;

  function automatic logic [2:0] seg_perm(input logic [2:0] seg);
    logic [2:0] p;
    case (seg)
      3'd0: p = 3'd5;
      3'd1: p = 3'd7;
      3'd2: p = 3'd6;
      3'd3: p = 3'd4;
      3'd4: p = 3'd1;
      3'd5: p = 3'd3;
      3'd6: p = 3'd0;
      default: p = 3'd2;
    endcase
    return p;
  endfunction

  // brightness bit, status leds and one-cold segment select
  function automatic logic [15:0] aux_word(input logic bright, input logic [4:0] leds,
                                           input logic [2:0] seg);
    logic [15:0] w;
    w = bright ? AUX_BRIGHT_HI : AUX_BRIGHT_LO;
    w = w | {10'd0, leds, 1'b0};
    w = w | (AUX_SEL_ALL ^ (AUX_SEL_ONE << seg_perm(seg)));
    return w;
  endfunction

endpackage

>>> rtl/bcm_front.sv
// front part: config registers, scan state, frame store and read stage
// depends on bcm_pkg; pushes finished bit-cycle jobs into bcm_queue
module bcm_front #(
  parameter int SEGMENTS         = bcm_pkg::SEGMENTS_DEF,
  parameter int MAX_PLANES       = bcm_pkg::MAX_PLANES_DEF,
  parameter int DRIVER_WORD_BITS = bcm_pkg::DRIVER_WORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_addr,
  input  logic [7:0]               cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_action,
  input  logic [6:0]               in_address,
  input  logic [31:0]              in_data,
  input  logic [4:0]               in_status_leds,
  input  logic [bcm_pkg::QCNT_W-1:0] q_count,
  output logic                     push_valid,
  output bcm_pkg::job_t            push_job
);
  import bcm_pkg::*;

  localparam int BANK_WORDS = MAX_PLANES * SEGMENTS;
  localparam int ADDR_W     = $clog2(BANK_WORDS);
  localparam int MIDX_W     = $clog2(2 * BANK_WORDS);
  localparam int SEG_W      = $clog2(SEGMENTS);
  localparam int PSUM_W     = MAX_PLANES + 8;

  logic [3:0] bit_planes_r;
  logic [6:0] period_base_r;
  logic [7:0] period_offset_r;
  logic       front_r, front_nxt;
  logic       pend_r, pend_nxt;
  logic [1:0] bright_r, bright_nxt;
  logic [3:0] plane_r, plane_nxt;
  logic [SEG_W-1:0] seg_r, seg_nxt;
  logic [BANK_WORDS-1:0] vld0_r, vld0_nxt;

  logic s1_valid_r, s1_valid_nxt;
  logic s1_use_r, s1_use_nxt;
  job_t s1_job_r, s1_job_nxt;
  logic [DRIVER_WORD_BITS-1:0] rd_data_r;
  logic [DRIVER_WORD_BITS-1:0] mem [2*BANK_WORDS];

  logic accept, back_bank, plane_ok, wrap, seg_last, swap, bit_go;
  logic mem_we, mem_re;
  logic [MIDX_W-1:0] waddr, raddr;
  logic [ADDR_W-1:0] rd_off;
  logic [3:0] plane_inc;
  logic [PSUM_W-1:0] psum;
  logic [15:0] period;

  // room for the job in flight in the read stage is held back
  assign in_stall = ({1'b0, q_count} + (QCNT_W + 1)'(s1_valid_r))
                    >= (QCNT_W + 1)'(QUEUE_DEPTH);
  assign accept   = in_valid && !in_stall;
  assign back_bank = ~front_r;
  assign bit_go   = accept && (in_action == ACT_BIT_CYCLE);

  assign plane_ok  = plane_r < 4'(MAX_PLANES);
  assign plane_inc = plane_ok ? plane_r + 4'd1 : plane_r;
  assign wrap      = plane_inc >= bit_planes_r;
  assign seg_last  = seg_r == SEG_W'(SEGMENTS - 1);
  assign swap      = wrap && seg_last && pend_r;

  assign rd_off = ADDR_W'(int'(plane_r) * SEGMENTS + int'(seg_r));
  assign raddr  = MIDX_W'(int'(front_r) * BANK_WORDS + int'(rd_off));
  assign waddr  = MIDX_W'(int'(back_bank) * BANK_WORDS + int'(in_address[ADDR_W-1:0]));
  assign mem_we = accept && (in_action == ACT_WRITE_WORD) && (in_address < 7'(BANK_WORDS));
  assign mem_re = bit_go && plane_ok;

  always_comb begin
    if (plane_inc >= 4'(MAX_PLANES)) begin
      psum = PSUM_W'(period_offset_r) + PSUM_W'(period_base_r);
    end else begin
      psum = PSUM_W'(period_offset_r) + (PSUM_W'(period_base_r) << plane_inc);
    end
    if (32'(psum) > 32'(PERIOD_MAX)) begin
      period = PERIOD_MAX;
    end else begin
      period = 16'(psum);
    end
  end

  always_comb begin
    front_nxt    = front_r;
    pend_nxt     = pend_r;
    bright_nxt   = bright_r;
    plane_nxt    = plane_r;
    seg_nxt      = seg_r;
    vld0_nxt     = vld0_r;
    s1_valid_nxt = bit_go;
    s1_use_nxt   = s1_use_r;
    s1_job_nxt   = s1_job_r;
    if (mem_we && !back_bank) begin
      vld0_nxt[in_address[ADDR_W-1:0]] = 1'b1;
    end
    if (accept) begin
      case (in_action)
        ACT_WRITE_WORD: begin
        end
        ACT_WRITE_BRIGHT: begin
          bright_nxt[back_bank] = in_data[0];
        end
        ACT_SWAP: begin
          pend_nxt = 1'b1;
        end
        default: begin
          if (wrap) begin
            plane_nxt = 4'd0;
            seg_nxt   = seg_last ? '0 : seg_r + SEG_W'(1);
          end else begin
            plane_nxt = plane_inc;
          end
          if (swap) begin
            front_nxt = ~front_r;
            pend_nxt  = 1'b0;
          end
          // unwritten entries of the reset front bank read as zero
          s1_use_nxt          = plane_ok && (front_r || vld0_r[rd_off]);
          s1_job_nxt.wrap     = wrap;
          s1_job_nxt.word     = '0;
          s1_job_nxt.period   = period;
          s1_job_nxt.read_seg = 3'(seg_r);
          s1_job_nxt.plane    = plane_nxt;
          s1_job_nxt.aux_seg  = 3'(seg_nxt);
          s1_job_nxt.aux      = aux_word(bright_r[front_nxt], in_status_leds, 3'(seg_nxt));
        end
      endcase
    end
  end

  always_comb begin
    push_valid = s1_valid_r;
    push_job   = s1_job_r;
    push_job.word = s1_use_r ? 32'(rd_data_r) : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= in_data[DRIVER_WORD_BITS-1:0];
    end
    if (mem_re) begin
      rd_data_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    s1_use_r <= s1_use_nxt;
    s1_job_r <= s1_job_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_planes_r    <= BIT_PLANES_RST;
      period_base_r   <= PERIOD_BASE_RST;
      period_offset_r <= PERIOD_OFFSET_RST;
      front_r    <= 1'b0;
      pend_r     <= 1'b0;
      bright_r   <= 2'b01;
      plane_r    <= 4'd0;
      seg_r      <= '0;
      vld0_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_BIT_PLANES:    bit_planes_r    <= cfg_wdata[3:0];
          CFG_PERIOD_BASE:   period_base_r   <= cfg_wdata[6:0];
          CFG_PERIOD_OFFSET: period_offset_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      front_r    <= front_nxt;
      pend_r     <= pend_nxt;
      bright_r   <= bright_nxt;
      plane_r    <= plane_nxt;
      seg_r      <= seg_nxt;
      vld0_r     <= vld0_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

endmodule

>>> rtl/bcm_queue.sv
// short job queue between the front and back parts
// depends on bcm_pkg for the job type and depth
module bcm_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  bcm_pkg::job_t              push_job,
  input  logic                       pop,
  output logic                       head_valid,
  output bcm_pkg::job_t              head_job,
  output logic [bcm_pkg::QCNT_W-1:0] count
);
  import bcm_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  job_t q_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign head_valid = count_r != '0;
  assign head_job   = q_mem[rd_ptr_r];
  assign count      = count_r;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> rtl/bcm_back.sv
// back part: turns each job into a driver result and, on wrap, an aux result
// depends on bcm_pkg; drives the output register of the block
module bcm_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  bcm_pkg::job_t head_job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          out_kind,
  output logic [31:0]   out_word,
  output logic [15:0]   out_next_period,
  output logic [2:0]    out_segment,
  output logic [3:0]    out_plane,
  output logic          out_last
);
  import bcm_pkg::*;

  logic        valid_r, valid_nxt;
  logic        aux_pend_r, aux_pend_nxt;
  logic        kind_r, kind_nxt;
  logic [31:0] word_r, word_nxt;
  logic [15:0] period_r, period_nxt;
  logic [2:0]  seg_r, seg_nxt;
  logic [3:0]  plane_r, plane_nxt;
  logic        last_r, last_nxt;
  logic [15:0] aux_r, aux_nxt;
  logic [2:0]  aux_seg_r, aux_seg_nxt;
  logic        take;

  assign take = !valid_r || !out_stall;
  assign pop  = take && !aux_pend_r && head_valid;

  always_comb begin
    valid_nxt    = valid_r;
    aux_pend_nxt = aux_pend_r;
    kind_nxt     = kind_r;
    word_nxt     = word_r;
    period_nxt   = period_r;
    seg_nxt      = seg_r;
    plane_nxt    = plane_r;
    last_nxt     = last_r;
    aux_nxt      = aux_r;
    aux_seg_nxt  = aux_seg_r;
    if (take) begin
      if (aux_pend_r) begin
        valid_nxt    = 1'b1;
        aux_pend_nxt = 1'b0;
        kind_nxt     = KIND_AUX;
        word_nxt     = {16'd0, aux_r};
        period_nxt   = 16'd0;
        seg_nxt      = aux_seg_r;
        last_nxt     = 1'b1;
      end else if (head_valid) begin
        valid_nxt    = 1'b1;
        aux_pend_nxt = head_job.wrap;
        kind_nxt     = KIND_DRIVER;
        word_nxt     = head_job.word;
        period_nxt   = head_job.period;
        seg_nxt      = head_job.read_seg;
        plane_nxt    = head_job.plane;
        last_nxt     = !head_job.wrap;
        aux_nxt      = head_job.aux;
        aux_seg_nxt  = head_job.aux_seg;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    word_r    <= word_nxt;
    period_r  <= period_nxt;
    seg_r     <= seg_nxt;
    plane_r   <= plane_nxt;
    last_r    <= last_nxt;
    aux_r     <= aux_nxt;
    aux_seg_r <= aux_seg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      aux_pend_r <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      aux_pend_r <= aux_pend_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_kind        = kind_r;
  assign out_word        = word_r;
  assign out_next_period = period_r;
  assign out_segment     = seg_r;
  assign out_plane       = plane_r;
  assign out_last        = last_r;

endmodule

>>> rtl/bcm_multiplexed_led_scanner.sv
// a driver word passes the read stage, the job queue and then the output register
// requests are taken one a cycle while in_stall is low; each bit cycle gives a driver
// result, and when the plane wraps the aux result follows it
// writes and swap requests finish in the cycle they are taken and give no result
// reset (synchronous, rst_n low): registers to defaults, scan at plane 0 segment 0,
// reset front bank reads zero through per-entry valid bits, no clearing pass
module bcm_multiplexed_led_scanner #(
  parameter int SEGMENTS         = bcm_pkg::SEGMENTS_DEF,
  parameter int MAX_PLANES       = bcm_pkg::MAX_PLANES_DEF,
  parameter int DRIVER_WORD_BITS = bcm_pkg::DRIVER_WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [6:0]  in_address,
  input  logic [31:0] in_data,
  input  logic [4:0]  in_status_leds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [31:0] out_word,
  output logic [15:0] out_next_period,
  output logic [2:0]  out_segment,
  output logic [3:0]  out_plane,
  output logic        out_last
);
  import bcm_pkg::*;

  logic              push_valid, pop, head_valid;
  job_t              push_job, head_job;
  logic [QCNT_W-1:0] q_count;

  bcm_front #(
    .SEGMENTS         (SEGMENTS),
    .MAX_PLANES       (MAX_PLANES),
    .DRIVER_WORD_BITS (DRIVER_WORD_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_address     (in_address),
    .in_data        (in_data),
    .in_status_leds (in_status_leds),
    .q_count        (q_count),
    .push_valid     (push_valid),
    .push_job       (push_job)
  );

  bcm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_job   (push_job),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job),
    .count      (q_count)
  );

  bcm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_job        (head_job),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_word        (out_word),
    .out_next_period (out_next_period),
    .out_segment     (out_segment),
    .out_plane       (out_plane),
    .out_last        (out_last)
  );

endmodule

>>> rtl/bcm_checker.sv
// port-level checks of the led scan block's result stream
// depends on bcm_pkg; bound to bcm_multiplexed_led_scanner below
module bcm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_kind,
  input logic [31:0] out_word,
  input logic [15:0] out_next_period,
  input logic        out_last
);
  import bcm_pkg::*;

  // an aux word always closes its event
  a_aux_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_AUX) |-> out_last)
    else $error("aux result without last");

  // a wrapping driver word is followed at once by its aux word
  a_aux_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && (out_kind == KIND_DRIVER) && !out_last
    |=> out_valid && (out_kind == KIND_AUX))
    else $error("aux result missing after wrapping driver word");

  // aux carries no period and only 16 bits
  a_aux_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_AUX) |-> (out_next_period == 16'd0)
    && (out_word[31:16] == 16'd0))
    else $error("aux result with period or high bits");

  // exactly one segment select line is driven low
  a_aux_onecold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_AUX) |-> ($countones(out_word[15:8]) == 7))
    else $error("aux segment select not one-cold");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word) && $stable(out_kind))
    else $error("stalled result changed");

endmodule

bind bcm_multiplexed_led_scanner bcm_checker u_bcm_checker (.*);

>>> verif/tb_bcm_multiplexed_led_scanner.sv
// self-checking testbench for the bcm led scan block: directed tests, then random traffic
// keeps its own scan state to predict driver and aux words; depends on bcm_pkg and the rtl top
module tb_bcm_multiplexed_led_scanner;
  timeunit 1ns;
  timeprecision 1ps;
  import bcm_pkg::*;

  localparam int SEG_N          = SEGMENTS_DEF;
  localparam int PLANE_N        = MAX_PLANES_DEF;
  localparam int STORE_WORDS    = SEG_N * PLANE_N;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 5000;
  // select line per segment, segment 0 in the low bits
  localparam logic [23:0] SEL_ORDER = {3'd2, 3'd0, 3'd3, 3'd1, 3'd4, 3'd6, 3'd7, 3'd5};

  typedef struct packed {
    logic        kind;
    logic [31:0] word;
    logic [15:0] next_period;
    logic [2:0]  segment;
    logic [3:0]  plane;
    logic        last;
  } scan_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = CFG_BIT_PLANES;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = ACT_WRITE_WORD;
  logic [6:0]  in_address = 7'd0;
  logic [31:0] in_data = 32'd0;
  logic [4:0]  in_status_leds = 5'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_kind;
  logic [31:0] out_word;
  logic [15:0] out_next_period;
  logic [2:0]  out_segment;
  logic [3:0]  out_plane;
  logic        out_last;

  // shadow of the scan state
  logic [31:0] frame_words [2][STORE_WORDS];
  bit          entry_loaded [2][STORE_WORDS];
  logic        bank_bright [2];
  logic        front_sel;
  bit          swap_armed;
  int          cur_plane;
  int          cur_segment;
  int          cfg_planes;
  int          cfg_base;
  int          cfg_offset;

  scan_result_t expected_results[$];
  scan_result_t oldest_due;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int fail_count = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int swaps_done = 0;
  int reg_writes = 0;
  int idle_cycles = 0;

  bcm_multiplexed_led_scanner dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_address(in_address),
    .in_data(in_data),
    .in_status_leds(in_status_leds),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_word(out_word),
    .out_next_period(out_next_period),
    .out_segment(out_segment),
    .out_plane(out_plane),
    .out_last(out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  function automatic logic [15:0] timer_period(input int slot);
    int p;
    if (slot >= PLANE_N) p = cfg_offset + cfg_base;
    else p = cfg_offset + (cfg_base << slot);
    return (p > 'hFFFF) ? PERIOD_MAX : p[15:0];
  endfunction

  task automatic predict_request(input logic [1:0] act, input logic [6:0] addr,
                                 input logic [31:0] data, input logic [4:0] leds);
    logic         back;
    logic [31:0]  word;
    logic [15:0]  period;
    logic [15:0]  aux;
    int           read_seg;
    bit           wrap;
    back = ~front_sel;
    case (act)
      ACT_WRITE_WORD: begin
        if (addr < STORE_WORDS) begin
          frame_words[back][addr] = data;
          entry_loaded[back][addr] = 1'b1;
        end
      end
      ACT_WRITE_BRIGHT: bank_bright[back] = data[0];
      ACT_SWAP: swap_armed = 1'b1;
      default: begin
        read_seg = cur_segment;
        word = '0;
        if (cur_plane < PLANE_N) begin
          word = frame_words[front_sel][cur_plane * SEG_N + cur_segment];
          cur_plane++;
        end
        period = timer_period(cur_plane);
        wrap = (cur_plane >= cfg_planes);
        if (wrap) begin
          cur_plane = 0;
          if (cur_segment == SEG_N - 1) begin
            cur_segment = 0;
            // a pending swap only lands when the scan wraps back to segment 0
            if (swap_armed) begin
              front_sel = ~front_sel;
              swap_armed = 1'b0;
              swaps_done++;
            end
          end else begin
            cur_segment++;
          end
        end
        expected_results.push_back({KIND_DRIVER, word, period, 3'(read_seg), 4'(cur_plane),
                                    !wrap});
        if (wrap) begin
          aux = (bank_bright[front_sel] ? AUX_BRIGHT_HI : AUX_BRIGHT_LO) | {10'd0, leds, 1'b0}
                | (AUX_SEL_ALL ^ (AUX_SEL_ONE << SEL_ORDER[cur_segment * 3 +: 3]));
          expected_results.push_back({KIND_AUX, {16'd0, aux}, 16'd0, 3'(cur_segment),
                                      4'(cur_plane), 1'b1});
        end
      end
    endcase
  endtask

  task automatic send_request(input logic [1:0] act, input logic [6:0] addr,
                              input logic [31:0] data, input logic [4:0] leds);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_address <= addr;
    in_data <= data;
    in_status_leds <= leds;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    predict_request(act, addr, data, leds);
    requests_sent++;
  endtask

  task automatic bit_cycle(input logic [4:0] leds);
    send_request(ACT_BIT_CYCLE, 7'($urandom), $urandom, leds);
  endtask

  // stop sending and let every outstanding result come out
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    settle_block();
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_BIT_PLANES:  cfg_planes = value[3:0];
      CFG_PERIOD_BASE: cfg_base = value[6:0];
      default:         cfg_offset = value;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d word %0h segment %0d", out_kind, out_word,
               out_segment);
        fail_count++;
      end else begin
        oldest_due = expected_results.pop_front();
        check_field("kind", 32'(oldest_due.kind), 32'(out_kind));
        check_field("word", oldest_due.word, out_word);
        check_field("next_period", 32'(oldest_due.next_period), 32'(out_next_period));
        check_field("segment", 32'(oldest_due.segment), 32'(out_segment));
        check_field("plane", 32'(oldest_due.plane), 32'(out_plane));
        check_field("last", 32'(oldest_due.last), 32'(out_last));
        results_checked++;
      end
    end
  end

  // counts cycles in which neither channel moves
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("bcm_multiplexed_led_scanner verification failed");
        $finish;
      end
    end
  end

  task automatic reset_prediction();
    for (int i = 0; i < STORE_WORDS; i++) begin
      frame_words[0][i] = '0;
      frame_words[1][i] = '0;
      entry_loaded[0][i] = 1'b1;
      entry_loaded[1][i] = 1'b0;
    end
    bank_bright[0] = 1'b1;
    bank_bright[1] = 1'b0;
    front_sel = 1'b0;
    swap_armed = 1'b0;
    cur_plane = 0;
    cur_segment = 0;
    cfg_planes = BIT_PLANES_RST;
    cfg_base = PERIOD_BASE_RST;
    cfg_offset = PERIOD_OFFSET_RST;
  endtask

  // default registers, zero front bank, first wrap at plane ten
  task automatic test_reset_scan();
    logic [4:0] led_pat [4];
    led_pat = '{5'h00, 5'h1f, 5'h15, 5'h0a};
    for (int i = 0; i < 10; i++) bit_cycle(led_pat[i % 4]);
  endtask

  // back bank writes stay hidden, out of range addresses are dropped
  task automatic test_back_writes();
    send_request(ACT_WRITE_WORD, 7'd0, 32'h0000_0000, 5'h1f);
    send_request(ACT_WRITE_WORD, 7'd79, 32'hffff_ffff, 5'h00);
    send_request(ACT_WRITE_WORD, 7'd80, 32'haaaa_aaaa, 5'h15);
    send_request(ACT_WRITE_WORD, 7'd127, 32'h5555_5555, 5'h0a);
    send_request(ACT_WRITE_BRIGHT, 7'd3, 32'hffff_fffe, 5'h00);
    send_request(ACT_WRITE_BRIGHT, 7'd3, 32'h0000_0001, 5'h00);
    for (int i = 0; i < 3; i++) bit_cycle(5'($urandom));
  endtask

  // load a whole frame, request the swap twice and scan until it lands
  task automatic test_frame_swap();
    int fill_order [STORE_WORDS];
    int j;
    int tmp;
    for (int i = 0; i < STORE_WORDS; i++) fill_order[i] = i;
    for (int i = STORE_WORDS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = fill_order[i];
      fill_order[i] = fill_order[j];
      fill_order[j] = tmp;
    end
    write_reg(CFG_BIT_PLANES, 8'd1);
    for (int i = 0; i < STORE_WORDS; i++)
      send_request(ACT_WRITE_WORD, 7'(fill_order[i]), $urandom, 5'($urandom));
    send_request(ACT_WRITE_BRIGHT, 7'($urandom), $urandom, 5'($urandom));
    send_request(ACT_SWAP, 7'($urandom), $urandom, 5'($urandom));
    send_request(ACT_SWAP, 7'($urandom), $urandom, 5'($urandom));
    while (swap_armed) bit_cycle(5'($urandom));
    bit_cycle(5'($urandom));
  endtask

  // zero planes, saturated plane index and period register extremes
  task automatic test_plane_limits();
    write_reg(CFG_BIT_PLANES, 8'd0);
    for (int i = 0; i < 3; i++) bit_cycle(5'($urandom));
    write_reg(CFG_BIT_PLANES, 8'd15);
    for (int i = 0; i < 12; i++) bit_cycle(5'($urandom));
    write_reg(CFG_BIT_PLANES, 8'd10);
    write_reg(CFG_PERIOD_BASE, 8'hff);
    write_reg(CFG_PERIOD_OFFSET, 8'd255);
    for (int i = 0; i < 11; i++) bit_cycle(5'($urandom));
    write_reg(CFG_PERIOD_BASE, 8'd0);
    write_reg(CFG_PERIOD_OFFSET, 8'd0);
    write_reg(CFG_BIT_PLANES, 8'd3);
    for (int i = 0; i < 3; i++) bit_cycle(5'($urandom));
    write_reg(CFG_PERIOD_BASE, 8'd1);
    write_reg(CFG_BIT_PLANES, 8'd1);
    for (int i = 0; i < 2; i++) bit_cycle(5'($urandom));
    write_reg(CFG_PERIOD_BASE, 8'd64);
    for (int i = 0; i < 2; i++) bit_cycle(5'($urandom));
  endtask

  task automatic random_request();
    int          pick;
    bit          back_full;
    logic [6:0]  addr;
    logic [31:0] data;
    data = $urandom;
    if ($urandom_range(0, 9) == 0) data = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
    addr = ($urandom_range(0, 19) == 0) ? 7'($urandom_range(80, 127))
                                        : 7'($urandom_range(0, STORE_WORDS - 1));
    back_full = 1'b1;
    for (int i = 0; i < STORE_WORDS; i++)
      if (!entry_loaded[~front_sel][i]) back_full = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 45 || (pick >= 93 && !back_full))
      send_request(ACT_BIT_CYCLE, 7'($urandom), data, 5'($urandom));
    else if (pick < 85) send_request(ACT_WRITE_WORD, addr, data, 5'($urandom));
    else if (pick < 93) send_request(ACT_WRITE_BRIGHT, addr, data, 5'($urandom));
    else send_request(ACT_SWAP, addr, data, 5'($urandom));
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 67; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 67; end
        default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
      for (int s = 0; s < 2; s++) begin
        write_reg(CFG_BIT_PLANES, ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 15))
                                                              : 8'($urandom_range(1, 10)));
        write_reg(CFG_PERIOD_BASE, 8'($urandom));
        write_reg(CFG_PERIOD_OFFSET, 8'($urandom));
        for (int n = 0; n < 157; n++) random_request();
      end
    end
  endtask

  initial begin
    reset_prediction();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_scan();
    test_back_writes();
    test_frame_swap();
    test_plane_limits();
    test_random_traffic();
    settle_block();
    repeat (16) @(posedge clk);
    $display("%0d requests sent, %0d results checked", requests_sent, results_checked);
    $display("%0d bank swaps, %0d register writes, idle and stall mixes applied",
             swaps_done, reg_writes);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("bcm_multiplexed_led_scanner verification clean");
    end else begin
      $display("bcm_multiplexed_led_scanner verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/bcm_pkg.sv
rtl/bcm_front.sv
rtl/bcm_queue.sv
rtl/bcm_back.sv
rtl/bcm_multiplexed_led_scanner.sv
rtl/bcm_checker.sv
verif/tb_bcm_multiplexed_led_scanner.sv
